// File: rtl/core/ggp_pkg.sv
// ----------------------------------------------------------------------------
// ggp_pkg
// Shared types, register codes and arithmetic helpers of the grain player.
// ----------------------------------------------------------------------------
package ggp_pkg;

   localparam int SAMPLE_DEPTH_DEF = 65536;
   localparam int WINDOW_SIZE_DEF  = 512;
   localparam int CSR_AW           = 5;
   localparam int CSR_DW           = 32;

   localparam logic [63:0] PIQ30   = 64'd3373259426;
   localparam logic [63:0] ONE_Q30 = 64'd1 << 30;

   localparam logic [2:0] REG_MIX_MODE      = 3'd0;
   localparam logic [2:0] REG_SPEED_STEP    = 3'd1;
   localparam logic [2:0] REG_PITCH_STEP    = 3'd2;
   localparam logic [2:0] REG_START_FRAC    = 3'd3;
   localparam logic [2:0] REG_LENGTH_FRAC   = 3'd4;
   localparam logic [2:0] REG_SMOOTHNESS    = 3'd5;
   localparam logic [2:0] REG_SAMPLE_COUNT  = 3'd6;

   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_FRAME = 1'b1;

   localparam logic [1:0] MOD_SEL_K     = 2'd0;
   localparam logic [1:0] MOD_SEL_PITCH = 2'd1;
   localparam logic [1:0] MOD_SEL_SRC   = 2'd2;

   typedef struct packed {
      logic        mix_mode;
      logic [23:0] speed_step;
      logic [23:0] pitch_step;
      logic [16:0] start_fraction;
      logic [16:0] length_fraction;
      logic [16:0] window_smoothness;
      logic [16:0] sample_count;
   } cfg_type;

   typedef struct packed {
      logic       load_wr;
      logic       capture;
      logic       region_l;
      logic       region_s;
      logic       mod_start;
      logic [1:0] mod_sel;
      logic       k_init;
      logic       q_init;
      logic       ent_rd1;
      logic       ent_rd2;
      logic       ent_mul1;
      logic       ent_mul2;
      logic       ent_mul3;
      logic       ent_wr;
      logic       g_rd;
      logic       mix;
      logic       sp_upd;
      logic       out_load;
      logic       out_pass;
   } dp_cmd_type;

   typedef struct packed {
      logic n_zero;
      logic grain_empty;
      logic last_entry;
      logic mod_done;
   } dp_status_type;

   function automatic logic signed [15:0] sat16(input logic signed [39:0] v);
      logic signed [15:0] r;
      if (v > 40'sd32767) r = 16'sh7fff;
      else if (v < -40'sd32768) r = 16'sh8000;
      else r = v[15:0];
      return r;
   endfunction

   function automatic logic [16:0] clamp_one(input logic [16:0] v);
      return (v > 17'd65536) ? 17'd65536 : v;
   endfunction

   // Hann value in Q0.16 from phase p in Q0.32, sine by odd series to theta^9
   function automatic logic [15:0] hann_q16(input logic [63:0] p);
      logic [63:0] y;
      logic [63:0] th;
      logic [63:0] t2;
      logic [63:0] h;
      logic [63:0] s;
      logic [63:0] w;
      if (p <= 64'h8000_0000) y = p;
      else if (p >= 64'h1_0000_0000) y = 64'd0;
      else y = 64'h1_0000_0000 - p;
      th = (y * PIQ30) >> 32;
      t2 = (th * th) >> 30;
      h  = ONE_Q30 - t2 / 72;
      h  = ONE_Q30 - ((t2 * h) >> 30) / 42;
      h  = ONE_Q30 - ((t2 * h) >> 30) / 20;
      h  = ONE_Q30 - ((t2 * h) >> 30) / 6;
      s  = (th * h) >> 30;
      w  = (s * s + (64'd1 << 43)) >> 44;
      if (w > 64'd65535) w = 64'd65535;
      return w[15:0];
   endfunction

endpackage

// File: rtl/core/ggp_mod.sv
// ----------------------------------------------------------------------------
// ggp_mod
// Bit-serial remainder unit, one restoring step per cycle.
// ----------------------------------------------------------------------------
module ggp_mod (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [16:0] dividend,
   input  logic [16:0] divisor,
   output logic        done,
   output logic [16:0] remainder
);
   import ggp_pkg::*;

   logic        busy_ff;
   logic        done_ff;
   logic [4:0]  cnt_ff;
   logic [16:0] num_ff;
   logic [16:0] rem_ff;
   logic [17:0] trial;
   logic [17:0] rem_in;

   always_comb begin
      trial = {rem_ff, num_ff[16]};
      if (trial >= {1'b0, divisor}) rem_in = trial - {1'b0, divisor};
      else rem_in = trial;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 5'd0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= 5'd17;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 5'd1;
            if (cnt_ff == 5'd1) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         num_ff <= dividend;
         rem_ff <= 17'd0;
      end else if (busy_ff) begin
         num_ff <= {num_ff[15:0], 1'b0};
         rem_ff <= rem_in[16:0];
      end
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

// File: rtl/core/ggp_csr.sv
// ----------------------------------------------------------------------------
// ggp_csr
// Configuration registers behind the APB-style port.
// ----------------------------------------------------------------------------
module ggp_csr #(
   parameter int SAMPLE_DEPTH = ggp_pkg::SAMPLE_DEPTH_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [ggp_pkg::CSR_AW-1:0] paddr,
   input  logic [ggp_pkg::CSR_DW-1:0] pwdata,
   output logic [ggp_pkg::CSR_DW-1:0] prdata,
   output logic                       pready,
   output ggp_pkg::cfg_type           cfg
);
   import ggp_pkg::*;

   cfg_type     cfg_ff;
   logic        wr_en;
   logic [2:0]  idx;
   logic [16:0] cnt_w;

   assign wr_en = psel & penable & pwrite;
   assign idx   = paddr[4:2];
   assign cnt_w = pwdata[16:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (wr_en) begin
         unique case (idx)
            REG_MIX_MODE:     cfg_ff.mix_mode <= pwdata[0];
            REG_SPEED_STEP:   cfg_ff.speed_step <= pwdata[23:0];
            REG_PITCH_STEP:   cfg_ff.pitch_step <= pwdata[23:0];
            REG_START_FRAC:   cfg_ff.start_fraction <= clamp_one(pwdata[16:0]);
            REG_LENGTH_FRAC:  cfg_ff.length_fraction <= clamp_one(pwdata[16:0]);
            REG_SMOOTHNESS:   cfg_ff.window_smoothness <= clamp_one(pwdata[16:0]);
            REG_SAMPLE_COUNT: begin
               if (32'(cnt_w) > 32'(SAMPLE_DEPTH)) cfg_ff.sample_count <= 17'(SAMPLE_DEPTH);
               else cfg_ff.sample_count <= cnt_w;
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         REG_MIX_MODE:     prdata = 32'(cfg_ff.mix_mode);
         REG_SPEED_STEP:   prdata = 32'(cfg_ff.speed_step);
         REG_PITCH_STEP:   prdata = 32'(cfg_ff.pitch_step);
         REG_START_FRAC:   prdata = 32'(cfg_ff.start_fraction);
         REG_LENGTH_FRAC:  prdata = 32'(cfg_ff.length_fraction);
         REG_SMOOTHNESS:   prdata = 32'(cfg_ff.window_smoothness);
         REG_SAMPLE_COUNT: prdata = 32'(cfg_ff.sample_count);
         default:          prdata = 32'd0;
      endcase
   end

   assign pready = 1'b1;
   assign cfg    = cfg_ff;

endmodule

// File: rtl/core/ggp_dp.sv
// ----------------------------------------------------------------------------
// ggp_dp
// Datapath: sample memory, grain table, window ROM, grain arithmetic, mixer.
// ----------------------------------------------------------------------------
module ggp_dp #(
   parameter int SAMPLE_DEPTH = ggp_pkg::SAMPLE_DEPTH_DEF,
   parameter int WINDOW_SIZE  = ggp_pkg::WINDOW_SIZE_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  ggp_pkg::cfg_type       cfg,
   input  ggp_pkg::dp_cmd_type    cmd,
   output ggp_pkg::dp_status_type status,
   input  logic [31:0]            req_tdata,
   input  logic                   req_tlast,
   output logic [15:0]            rsp_mixed,
   output logic [15:0]            rsp_grain,
   output logic                   rsp_started,
   output logic                   rsp_last
);
   import ggp_pkg::*;

   localparam int AW = $clog2(SAMPLE_DEPTH);
   localparam int IW = $clog2(WINDOW_SIZE);

   logic signed [15:0] smem [SAMPLE_DEPTH];
   logic signed [15:0] gtab [WINDOW_SIZE];
   logic [15:0]        bell_rom [WINDOW_SIZE];

   for (genvar g = 0; g < WINDOW_SIZE; g++) begin : g_bell
      localparam logic [63:0] PH = (64'(g) << 32) / 64'(WINDOW_SIZE - 1);
      assign bell_rom[g] = hann_q16(PH);
   end

   logic [15:0]        value_ff;
   logic               last_ff;
   logic [15:0]        sp_int_ff;
   logic [15:0]        sp_frac_ff;
   logic [IW:0]        gidx_ff;
   logic               started_ff;
   logic [16:0]        len_ff;
   logic [16:0]        start_ff;
   logic [16:0]        k_ff;
   logic [15:0]        f_ff;
   logic [16:0]        q_ff;
   logic [IW-1:0]      i_ff;
   logic signed [15:0] smem_rd_ff;
   logic signed [15:0] s1_ff;
   logic [15:0]        b0_ff;
   logic [15:0]        b1_ff;
   logic signed [33:0] prod_s_ff;
   logic signed [33:0] prod_b_ff;
   logic signed [16:0] smp_ff;
   logic signed [35:0] prod_w_ff;
   logic signed [34:0] prod_e_ff;
   logic signed [15:0] g_rd_ff;
   logic signed [15:0] grain_ff;
   logic signed [15:0] mixed_ff;
   logic [15:0]        rsp_mixed_ff;
   logic [15:0]        rsp_grain_ff;
   logic               rsp_started_ff;
   logic               rsp_last_ff;

   logic [16:0]        n;
   logic [33:0]        prod_l;
   logic [33:0]        prod_st;
   logic [16:0]        l_raw;
   logic [16:0]        s_raw;
   logic [16:0]        mod_a;
   logic [16:0]        mod_rem;
   logic               mod_done;
   logic [16:0]        k2;
   logic [16:0]        k_inc;
   logic [IW-1:0]      i_nx;
   logic [16:0]        rd_sum;
   logic [AW-1:0]      rd_addr;
   logic [15:0]        ld_addr;
   logic               ld_ok;
   logic signed [16:0] ds;
   logic signed [16:0] db;
   logic signed [16:0] f_s;
   logic signed [16:0] bell;
   logic signed [17:0] bm;
   logic signed [17:0] w;
   logic [16:0]        fsum;
   logic [17:0]        kn0;
   logic [17:0]        kn1;
   logic [17:0]        kn2;
   logic [16:0]        spf_sum;
   logic [16:0]        spi_sum;
   logic signed [31:0] mprod;
   logic signed [15:0] mixed_in;

   assign n       = cfg.sample_count;
   assign prod_l  = 34'(cfg.length_fraction) * 34'(n);
   assign prod_st = 34'(cfg.start_fraction) * 34'(n);
   assign l_raw   = prod_l[32:16];
   assign s_raw   = prod_st[32:16];

   assign k_inc   = k_ff + 17'd1;
   assign k2      = (k_inc == len_ff) ? 17'd0 : k_inc;
   assign i_nx    = (i_ff == IW'(WINDOW_SIZE - 1)) ? '0 : i_ff + IW'(1);
   assign rd_sum  = start_ff + (cmd.ent_rd1 ? k_ff : k2);
   assign rd_addr = AW'(rd_sum);
   assign ld_addr = req_tdata[15:0];
   assign ld_ok   = 32'(ld_addr) < 32'(SAMPLE_DEPTH);

   assign f_s  = $signed({1'b0, f_ff});
   assign ds   = $signed({smem_rd_ff[15], smem_rd_ff}) - $signed({s1_ff[15], s1_ff});
   assign db   = $signed({1'b0, b1_ff}) - $signed({1'b0, b0_ff});
   assign bell = $signed({1'b0, b0_ff}) + $signed(prod_b_ff[32:16]);
   assign bm   = $signed({bell[16], bell}) - 18'sd65536;
   assign w    = 18'sd65536 + $signed(prod_w_ff[33:16]);

   assign fsum = {1'b0, f_ff} + {1'b0, cfg.pitch_step[15:0]};
   assign kn0  = 18'(k_ff) + 18'(q_ff) + 18'(fsum[16]);
   assign kn1  = (kn0 >= 18'(len_ff)) ? kn0 - 18'(len_ff) : kn0;
   assign kn2  = (kn1 >= 18'(len_ff)) ? kn1 - 18'(len_ff) : kn1;

   assign spf_sum = {1'b0, sp_frac_ff} + {1'b0, cfg.speed_step[15:0]};
   assign spi_sum = 17'(sp_int_ff) + 17'(cfg.speed_step[23:16]) + 17'(spf_sum[16]);

   always_comb begin
      case (cmd.mod_sel)
         MOD_SEL_K:     mod_a = 17'(sp_int_ff);
         MOD_SEL_PITCH: mod_a = 17'(cfg.pitch_step[23:16]);
         MOD_SEL_SRC:   mod_a = spi_sum;
         default:       mod_a = 17'd0;
      endcase
   end

   assign mprod = $signed(value_ff) * g_rd_ff;

   always_comb begin
      if (cfg.mix_mode) mixed_in = sat16(40'($signed(mprod[31:15])));
      else mixed_in = sat16(40'($signed(value_ff)) + 40'(g_rd_ff));
   end

   ggp_mod u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.mod_start),
      .dividend  (mod_a),
      .divisor   (len_ff),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         sp_int_ff  <= 16'd0;
         sp_frac_ff <= 16'd0;
         gidx_ff    <= (IW+1)'(WINDOW_SIZE);
         started_ff <= 1'b0;
      end else begin
         if (cmd.load_wr && ld_ok) begin
            sp_int_ff  <= 16'd0;
            sp_frac_ff <= 16'd0;
         end else if (cmd.sp_upd) begin
            sp_int_ff  <= mod_rem[15:0];
            sp_frac_ff <= spf_sum[15:0];
         end
         if (cmd.capture) started_ff <= 1'b0;
         else if (cmd.ent_wr && status.last_entry) started_ff <= 1'b1;
         if (cmd.ent_wr && status.last_entry) gidx_ff <= '0;
         else if (cmd.g_rd) gidx_ff <= gidx_ff + (IW+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_wr && ld_ok) smem[AW'(ld_addr)] <= $signed(req_tdata[31:16]);
      if (cmd.ent_rd1 || cmd.ent_rd2) smem_rd_ff <= smem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.ent_wr) gtab[i_ff] <= sat16(40'($signed(prod_e_ff[34:16])));
      if (cmd.g_rd) g_rd_ff <= gtab[gidx_ff[IW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (cmd.ent_rd1) begin
         b0_ff <= bell_rom[i_ff];
         b1_ff <= bell_rom[i_nx];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         value_ff <= req_tdata[31:16];
         last_ff  <= req_tlast;
      end
      if (cmd.region_l) len_ff <= (l_raw == 17'd0) ? 17'd1 : l_raw;
      if (cmd.region_s) begin
         if (18'(s_raw) + 18'(len_ff) >= 18'(n)) start_ff <= n - len_ff;
         else start_ff <= s_raw;
      end
      if (cmd.k_init) begin
         k_ff <= mod_rem;
         f_ff <= sp_frac_ff;
         i_ff <= '0;
      end else if (cmd.ent_wr) begin
         k_ff <= kn2[16:0];
         f_ff <= fsum[15:0];
         i_ff <= i_nx;
      end
      if (cmd.q_init) q_ff <= mod_rem;
      if (cmd.ent_rd2) s1_ff <= smem_rd_ff;
      if (cmd.ent_mul1) begin
         prod_s_ff <= ds * f_s;
         prod_b_ff <= db * f_s;
      end
      if (cmd.ent_mul2) begin
         smp_ff    <= $signed({s1_ff[15], s1_ff}) + $signed(prod_s_ff[32:16]);
         prod_w_ff <= bm * $signed({1'b0, cfg.window_smoothness});
      end
      if (cmd.ent_mul3) prod_e_ff <= smp_ff * w;
      if (cmd.mix) begin
         grain_ff <= g_rd_ff;
         mixed_ff <= mixed_in;
      end
      if (cmd.out_load) begin
         rsp_last_ff <= last_ff;
         if (cmd.out_pass) begin
            rsp_mixed_ff   <= value_ff;
            rsp_grain_ff   <= 16'd0;
            rsp_started_ff <= 1'b0;
         end else begin
            rsp_mixed_ff   <= mixed_ff;
            rsp_grain_ff   <= grain_ff;
            rsp_started_ff <= started_ff;
         end
      end
   end

   assign status.n_zero      = (n == 17'd0);
   assign status.grain_empty = (gidx_ff >= (IW+1)'(WINDOW_SIZE));
   assign status.last_entry  = (i_ff == IW'(WINDOW_SIZE - 1));
   assign status.mod_done    = mod_done;

   assign rsp_mixed   = rsp_mixed_ff;
   assign rsp_grain   = rsp_grain_ff;
   assign rsp_started = rsp_started_ff;
   assign rsp_last    = rsp_last_ff;

endmodule

// File: rtl/core/ggp_ctrl.sv
// ----------------------------------------------------------------------------
// ggp_ctrl
// Sequencer for load and frame items; drives the datapath commands.
// ----------------------------------------------------------------------------
module ggp_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_opcode,
   output logic                   req_tready,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  ggp_pkg::dp_status_type status,
   output ggp_pkg::dp_cmd_type    cmd
);
   import ggp_pkg::*;

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_CHK   = 4'd1;
   localparam logic [3:0] ST_RGN_S = 4'd2;
   localparam logic [3:0] ST_MOD_K = 4'd3;
   localparam logic [3:0] ST_MOD_Q = 4'd4;
   localparam logic [3:0] ST_RD1   = 4'd5;
   localparam logic [3:0] ST_RD2   = 4'd6;
   localparam logic [3:0] ST_MUL1  = 4'd7;
   localparam logic [3:0] ST_MUL2  = 4'd8;
   localparam logic [3:0] ST_MUL3  = 4'd9;
   localparam logic [3:0] ST_WR    = 4'd10;
   localparam logic [3:0] ST_G_RD  = 4'd11;
   localparam logic [3:0] ST_MIX   = 4'd12;
   localparam logic [3:0] ST_SP    = 4'd13;
   localparam logic [3:0] ST_OUT   = 4'd14;

   logic [3:0] state_ff;
   logic [3:0] state_in;
   logic       pass_ff;
   logic       pass_in;
   logic       valid_ff;
   logic       accept;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid & req_tready;
   assign rsp_tvalid = valid_ff;

   always_comb begin
      state_in = state_ff;
      pass_in  = pass_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_opcode == OP_LOAD) begin
                  cmd.load_wr = 1'b1;
               end else begin
                  cmd.capture = 1'b1;
                  state_in    = ST_CHK;
               end
            end
         end
         ST_CHK: begin
            pass_in = status.n_zero;
            if (status.n_zero) begin
               state_in = ST_OUT;
            end else begin
               cmd.region_l = 1'b1;
               state_in     = ST_RGN_S;
            end
         end
         ST_RGN_S: begin
            cmd.region_s = 1'b1;
            if (status.grain_empty) begin
               cmd.mod_start = 1'b1;
               cmd.mod_sel   = MOD_SEL_K;
               state_in      = ST_MOD_K;
            end else begin
               state_in = ST_G_RD;
            end
         end
         ST_MOD_K: begin
            cmd.mod_sel = MOD_SEL_K;
            if (status.mod_done) begin
               cmd.k_init    = 1'b1;
               cmd.mod_start = 1'b1;
               cmd.mod_sel   = MOD_SEL_PITCH;
               state_in      = ST_MOD_Q;
            end
         end
         ST_MOD_Q: begin
            cmd.mod_sel = MOD_SEL_PITCH;
            if (status.mod_done) begin
               cmd.q_init = 1'b1;
               state_in   = ST_RD1;
            end
         end
         ST_RD1: begin
            cmd.ent_rd1 = 1'b1;
            state_in    = ST_RD2;
         end
         ST_RD2: begin
            cmd.ent_rd2 = 1'b1;
            state_in    = ST_MUL1;
         end
         ST_MUL1: begin
            cmd.ent_mul1 = 1'b1;
            state_in     = ST_MUL2;
         end
         ST_MUL2: begin
            cmd.ent_mul2 = 1'b1;
            state_in     = ST_MUL3;
         end
         ST_MUL3: begin
            cmd.ent_mul3 = 1'b1;
            state_in     = ST_WR;
         end
         ST_WR: begin
            cmd.ent_wr = 1'b1;
            state_in   = status.last_entry ? ST_G_RD : ST_RD1;
         end
         ST_G_RD: begin
            cmd.g_rd = 1'b1;
            state_in = ST_MIX;
         end
         ST_MIX: begin
            cmd.mix       = 1'b1;
            cmd.mod_start = 1'b1;
            cmd.mod_sel   = MOD_SEL_SRC;
            state_in      = ST_SP;
         end
         ST_SP: begin
            cmd.mod_sel = MOD_SEL_SRC;
            if (status.mod_done) begin
               cmd.sp_upd = 1'b1;
               state_in   = ST_OUT;
            end
         end
         ST_OUT: begin
            cmd.out_pass = pass_ff;
            if (!valid_ff || rsp_tready) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pass_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pass_ff  <= pass_in;
         if (cmd.out_load) valid_ff <= 1'b1;
         else if (rsp_tready) valid_ff <= 1'b0;
      end
   end

endmodule

// File: rtl/core/granular_grain_player_core.sv
// ----------------------------------------------------------------------------
// granular_grain_player_core
// Granular sample player: sample loading, grain build and buffer mixing.
// ----------------------------------------------------------------------------
// Input channel req_*: tuser is the opcode (0 load, 1 frame). A load item
// writes one sample word and restarts the source position if its address
// is below SAMPLE_DEPTH. A frame item returns one result item on rsp_*; a
// load item returns none. When the current grain still has entries, a
// frame reads the next grain entry, mixes it and wraps the source position
// in the serial remainder; rsp_tvalid and req_tready then rise together.
// When the grain is used up a new table is built first: two remainders,
// then each window entry in turn through the single sample memory read
// port and the multiplier chain. One item is worked on at a time.
// The result register lets the next item be accepted while a result waits;
// a frame that finishes while rsp_tvalid is still held waits for it.
// Reset clears the configuration, the source position and the control
// state and marks the grain empty; the sample memory and the grain table
// hold nothing valid until written. The user must write registers over
// csr_* only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module granular_grain_player_core #(
   parameter int SAMPLE_DEPTH = ggp_pkg::SAMPLE_DEPTH_DEF,
   parameter int WINDOW_SIZE  = ggp_pkg::WINDOW_SIZE_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [31:0]                req_tdata,   // address[15:0], value[31:16]
   input  logic                       req_tuser,   // opcode
   input  logic                       req_tlast,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [31:0]                rsp_tdata,   // mixed_value[15:0], grain_value[31:16]
   output logic                       rsp_tuser,   // grain_started
   output logic                       rsp_tlast,
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [ggp_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [ggp_pkg::CSR_DW-1:0] csr_pwdata,
   output logic [ggp_pkg::CSR_DW-1:0] csr_prdata,
   output logic                       csr_pready
);
   import ggp_pkg::*;

   cfg_type       cfg;
   dp_cmd_type    cmd;
   dp_status_type status;
   logic [15:0]   rsp_mixed;
   logic [15:0]   rsp_grain;

   ggp_csr #(
      .SAMPLE_DEPTH (SAMPLE_DEPTH)
   ) u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   ggp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_opcode (req_tuser),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   ggp_dp #(
      .SAMPLE_DEPTH (SAMPLE_DEPTH),
      .WINDOW_SIZE  (WINDOW_SIZE)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .cmd         (cmd),
      .status      (status),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_mixed   (rsp_mixed),
      .rsp_grain   (rsp_grain),
      .rsp_started (rsp_tuser),
      .rsp_last    (rsp_tlast)
   );

   assign rsp_tdata = {rsp_grain, rsp_mixed};

   a_load_on_accept: assert property (@(posedge clock) disable iff (reset)
      cmd.load_wr |-> (req_tvalid && req_tready && !req_tuser))
      else $error("sample write without an accepted load item");

   a_one_entry_step: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.ent_rd1, cmd.ent_rd2, cmd.ent_mul1, cmd.ent_mul2, cmd.ent_mul3,
                cmd.ent_wr, cmd.g_rd, cmd.mix}))
      else $error("more than one datapath step in a cycle");

   a_out_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> rsp_tvalid)
      else $error("result loaded but not presented");

   a_no_mod_in_idle: assert property (@(posedge clock) disable iff (reset)
      (cmd.mod_start && cmd.load_wr) == 1'b0)
      else $error("remainder started during a load");

endmodule
